/* rtl/tssf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and field layouts of the TCP sample set fingerprinter.
package tssf_pkg;

  localparam int MAX_SAMPLES_DEF = 64;

  localparam logic [31:0] LIMIT_RESET = 32'd1000;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 88;

  localparam int FIN_BIT = 0;
  localparam int SYN_BIT = 1;
  localparam int RST_BIT = 2;
  localparam int PSH_BIT = 3;
  localparam int ACK_BIT = 4;

  localparam int NUM_FLAGS = 5;
  localparam int CNT_SYN   = 0;
  localparam int CNT_ACK   = 1;
  localparam int CNT_PSH   = 2;
  localparam int CNT_RST   = 3;
  localparam int CNT_FIN   = 4;

  localparam logic [6:0]  FLAG_CNT_MAX = 7'd127;
  localparam logic [5:0]  WIN_CNT_MAX  = 6'd63;
  localparam logic [15:0] IDENT_MAX    = 16'hFFFF;

  localparam int ID_INCR_BIT   = 0;
  localparam int ID_RANDOM_BIT = 1;
  localparam int ID_CONST_BIT  = 2;
  localparam int RISK_CONST_BIT = 0;
  localparam int RISK_INCR_BIT  = 1;

  localparam logic [3:0] RISK_ISN_CONST = 4'd4;
  localparam logic [3:0] RISK_ID_CONST  = 4'd3;
  localparam logic [3:0] RISK_ID_INCR   = 4'd2;
  localparam logic [3:0] RISK_STAMP     = 4'd2;

  typedef enum logic [1:0] {
    ISN_INSUFF  = 2'd0,
    ISN_RANDOM  = 2'd1,
    ISN_PREDICT = 2'd2,
    ISN_CONST   = 2'd3
  } isn_class_t;

  typedef enum logic [2:0] {
    ID_INSUFF  = 3'd0,
    ID_UNCLASS = 3'd1,
    ID_RANDOM  = 3'd2,
    ID_INCR    = 3'd3,
    ID_CONST   = 3'd4
  } ident_class_t;

  typedef logic [NUM_FLAGS-1:0][6:0] flag_cnt_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [8:0]  tcp_flags;
    logic [15:0] window_size;
    logic [31:0] stamp_value;
    logic [15:0] ident_value;
    logic [31:0] sequence_number;
  } sample_t;

  typedef struct packed {
    logic [31:0] prev_seq;
    logic [31:0] first_delta;
    logic [31:0] step_lo;
    logic [31:0] step_hi;
    logic        all_eq;
    logic [15:0] first_id;
    logic [15:0] prev_id;
    logic [2:0]  cls_flags;
    logic [1:0]  risk_flags;
    logic [31:0] first_stamp;
    logic        second_stamp_zero;
    logic [15:0] prev_win;
    logic [5:0]  win_cnt;
    flag_cnt_t   flag_cnt;
  } acc_t;

  localparam acc_t ACC_CLEAR = '{
    prev_seq:          32'd0,
    first_delta:       32'd0,
    step_lo:           32'd0,
    step_hi:           32'd0,
    all_eq:            1'b1,
    first_id:          16'd0,
    prev_id:           16'd0,
    cls_flags:         3'b111,
    risk_flags:        2'b11,
    first_stamp:       32'd0,
    second_stamp_zero: 1'b0,
    prev_win:          16'd0,
    win_cnt:           6'd0,
    flag_cnt:          '0
  };

  typedef struct packed {
    logic        ge2;
    logic        ge3;
    logic [31:0] step_lo;
    logic [31:0] step_hi;
    logic        all_eq;
    logic [2:0]  cls_flags;
    logic [1:0]  risk_flags;
    logic [31:0] first_stamp;
    logic        second_stamp_zero;
    logic [5:0]  win_cnt;
    flag_cnt_t   flag_cnt;
  } snap_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [3:0]   risk_total;
    logic         rst_warning;
    logic [6:0]   fin_total;
    logic [6:0]   rst_total;
    logic [6:0]   psh_total;
    logic [6:0]   ack_total;
    logic [6:0]   syn_total;
    logic [5:0]   win_change_total;
    logic         stamps_present;
    ident_class_t ident_class;
    logic [31:0]  delta_range;
    isn_class_t   isn_class;
  } result_t;

endpackage

/* rtl/tssf_accum.sv */
`timescale 1ns / 1ps
// Input register, per-set running statistics and snapshot of a closed set.
module tssf_accum #(
  parameter int MAX_SAMPLES = tssf_pkg::MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tssf_pkg::sample_t in_sample,
  input  logic              in_last,
  output logic              snap_valid,
  input  logic              snap_ready,
  output tssf_pkg::snap_t   snap
);
  import tssf_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

  logic             in_valid_r;
  logic             in_last_r;
  sample_t          in_sample_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  acc_t             acc_r, acc_nxt;
  logic             snap_valid_r;
  snap_t            snap_r, snap_nxt;

  logic        snap_free, advance, take, incr, same;
  logic [31:0] delta;
  logic [NUM_FLAGS-1:0] hits;

  assign snap_free = !snap_valid_r || snap_ready;
  assign advance   = in_valid_r && (!in_last_r || snap_free);
  assign in_ready  = !in_valid_r || advance;
  assign take      = count_r != CNT_FULL;

  assign delta = in_sample_r.sequence_number - acc_r.prev_seq;
  assign incr  = (acc_r.prev_id != IDENT_MAX) &&
                 (in_sample_r.ident_value == acc_r.prev_id + 16'd1);
  assign same  = in_sample_r.ident_value == acc_r.prev_id;

  assign hits[CNT_SYN] = in_sample_r.tcp_flags[SYN_BIT];
  assign hits[CNT_ACK] = in_sample_r.tcp_flags[ACK_BIT];
  assign hits[CNT_PSH] = in_sample_r.tcp_flags[PSH_BIT];
  assign hits[CNT_RST] = in_sample_r.tcp_flags[RST_BIT];
  assign hits[CNT_FIN] = in_sample_r.tcp_flags[FIN_BIT];

  always_comb begin
    acc_nxt   = acc_r;
    count_nxt = count_r;
    if (take) begin
      for (int k = 0; k < NUM_FLAGS; k++) begin
        if (hits[k] && acc_r.flag_cnt[k] != FLAG_CNT_MAX) begin
          acc_nxt.flag_cnt[k] = acc_r.flag_cnt[k] + 7'd1;
        end
      end
      if (count_r == '0) begin
        acc_nxt.first_id    = in_sample_r.ident_value;
        acc_nxt.first_stamp = in_sample_r.stamp_value;
      end else begin
        if (count_r == CNT_ONE) begin
          acc_nxt.first_delta       = delta;
          acc_nxt.step_lo           = delta;
          acc_nxt.step_hi           = delta;
          acc_nxt.second_stamp_zero = in_sample_r.stamp_value == 32'd0;
        end else begin
          if (delta != acc_r.first_delta) acc_nxt.all_eq = 1'b0;
          if (delta < acc_r.step_lo) acc_nxt.step_lo = delta;
          if (delta > acc_r.step_hi) acc_nxt.step_hi = delta;
          if (!incr) acc_nxt.cls_flags[ID_INCR_BIT] = 1'b0;
          if (in_sample_r.ident_value == acc_r.first_id) begin
            acc_nxt.cls_flags[ID_RANDOM_BIT] = 1'b0;
          end
          if (!same) acc_nxt.cls_flags[ID_CONST_BIT] = 1'b0;
        end
        if (!same) acc_nxt.risk_flags[RISK_CONST_BIT] = 1'b0;
        if (!incr) acc_nxt.risk_flags[RISK_INCR_BIT] = 1'b0;
        if (in_sample_r.window_size != acc_r.prev_win && acc_r.win_cnt != WIN_CNT_MAX) begin
          acc_nxt.win_cnt = acc_r.win_cnt + 6'd1;
        end
      end
      acc_nxt.prev_seq = in_sample_r.sequence_number;
      acc_nxt.prev_id  = in_sample_r.ident_value;
      acc_nxt.prev_win = in_sample_r.window_size;
      count_nxt        = count_r + CNT_ONE;
    end
  end

  always_comb begin
    snap_nxt.ge2               = count_nxt >= CNT_TWO;
    snap_nxt.ge3               = count_nxt >= CNT_THREE;
    snap_nxt.step_lo           = acc_nxt.step_lo;
    snap_nxt.step_hi           = acc_nxt.step_hi;
    snap_nxt.all_eq            = acc_nxt.all_eq;
    snap_nxt.cls_flags         = acc_nxt.cls_flags;
    snap_nxt.risk_flags        = acc_nxt.risk_flags;
    snap_nxt.first_stamp       = acc_nxt.first_stamp;
    snap_nxt.second_stamp_zero = acc_nxt.second_stamp_zero;
    snap_nxt.win_cnt           = acc_nxt.win_cnt;
    snap_nxt.flag_cnt          = acc_nxt.flag_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      in_last_r    <= 1'b0;
      count_r      <= '0;
      acc_r        <= ACC_CLEAR;
      snap_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
        in_last_r  <= in_last;
      end
      if (advance) begin
        if (in_last_r) begin
          count_r <= '0;
          acc_r   <= ACC_CLEAR;
        end else begin
          count_r <= count_nxt;
          acc_r   <= acc_nxt;
        end
      end
      if (advance && in_last_r) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_sample_r <= in_sample;
    end
    if (advance && in_last_r) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

/* rtl/tssf_report.sv */
`timescale 1ns / 1ps
// Report stage: classify a closed set and hold the result beat.
module tssf_report (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_valid,
  output logic              snap_ready,
  input  tssf_pkg::snap_t   snap,
  input  logic [31:0]       range_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output tssf_pkg::result_t result
);
  import tssf_pkg::*;

  logic        out_valid_r;
  result_t     result_r, result_nxt;
  logic [31:0] range;
  logic [3:0]  risk;

  assign snap_ready = !out_valid_r || out_ready;
  assign range      = snap.ge2 ? (snap.step_hi - snap.step_lo) : 32'd0;

  always_comb begin
    risk = 4'd0;
    if (snap.ge2) begin
      if (snap.all_eq) risk = risk + RISK_ISN_CONST;
      if (snap.ge3 && snap.risk_flags[RISK_CONST_BIT]) risk = risk + RISK_ID_CONST;
      if (snap.ge3 && snap.risk_flags[RISK_INCR_BIT]) risk = risk + RISK_ID_INCR;
      if (snap.first_stamp != 32'd0) risk = risk + RISK_STAMP;
    end
  end

  always_comb begin
    result_nxt.delta_range = range;
    if (!snap.ge2) begin
      result_nxt.isn_class = ISN_INSUFF;
    end else if (snap.all_eq) begin
      result_nxt.isn_class = ISN_CONST;
    end else if (range < range_limit) begin
      result_nxt.isn_class = ISN_PREDICT;
    end else begin
      result_nxt.isn_class = ISN_RANDOM;
    end
    if (!snap.ge3) begin
      result_nxt.ident_class = ID_INSUFF;
    end else if (snap.cls_flags[ID_CONST_BIT]) begin
      result_nxt.ident_class = ID_CONST;
    end else if (snap.cls_flags[ID_INCR_BIT]) begin
      result_nxt.ident_class = ID_INCR;
    end else if (snap.cls_flags[ID_RANDOM_BIT]) begin
      result_nxt.ident_class = ID_RANDOM;
    end else begin
      result_nxt.ident_class = ID_UNCLASS;
    end
    result_nxt.stamps_present   = snap.ge2 &&
                                  (snap.first_stamp != 32'd0 || !snap.second_stamp_zero);
    result_nxt.win_change_total = snap.win_cnt;
    result_nxt.syn_total        = snap.flag_cnt[CNT_SYN];
    result_nxt.ack_total        = snap.flag_cnt[CNT_ACK];
    result_nxt.psh_total        = snap.flag_cnt[CNT_PSH];
    result_nxt.rst_total        = snap.flag_cnt[CNT_RST];
    result_nxt.fin_total        = snap.flag_cnt[CNT_FIN];
    result_nxt.rst_warning      = snap.flag_cnt[CNT_RST] > (snap.flag_cnt[CNT_ACK] >> 1);
    result_nxt.risk_total       = risk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

/* rtl/tcp_sample_set_fingerprinter_top.sv */
`timescale 1ns / 1ps
// Top level of the TCP sample set fingerprinter.
//
//  channel  direction  beat contents
//  in_      slave      tdata: sequence_number, ident_value, stamp_value, window_size,
//                      tcp_flags; tlast: last_sample
//  out_     master     tdata: one set report, sent after each tlast beat
//  cfg_     write      predictable_range_limit
//
// One input beat per cycle while the snapshot register can take each closed set; the running
// statistics update between the input register and the snapshot register.
// A report passes from the input register through the snapshot and result registers to out_.
// Reset is synchronous: set state clears, the range limit returns to 1000.
// A stalled out_ holds its beat; in_ keeps flowing until a second closed set
// waits behind it, then in_tready drops on the next tlast beat.
module tcp_sample_set_fingerprinter_top #(
  parameter int MAX_SAMPLES = tssf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sequence_number, ident_value, stamp_value, window_size, tcp_flags, zero pad
  input  logic [tssf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // isn_class, delta_range, ident_class, stamps_present, win_change_total, syn_total,
  // ack_total, psh_total, rst_total, fin_total, rst_warning, risk_total, zero pad
  output logic [tssf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data
);
  import tssf_pkg::*;

  logic [31:0] limit_r;
  sample_t     sample;
  logic        snap_valid, snap_ready;
  snap_t       snap;
  result_t     result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign sample = in_tdata[$bits(sample_t)-1:0];

  tssf_accum #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (sample),
    .in_last    (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  tssf_report u_report (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap),
    .range_limit (limit_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .result      (result)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result};

endmodule

/* rtl/tssf_checker.sv */
`timescale 1ns / 1ps
// Port checker of the TCP sample set fingerprinter and its bind.
module tssf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tssf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tssf_pkg::*;

  logic [1:0] isn;
  logic [2:0] idc;
  logic [3:0] risk;

  assign isn  = out_tdata[1:0];
  assign idc  = out_tdata[36:34];
  assign risk = out_tdata[83:80];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat dropped or changed while stalled");

  a_insuff: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && isn == ISN_INSUFF |->
      out_tdata[33:2] == 32'd0 && risk == 4'd0 && idc == ID_INSUFF)
    else $error("short set reports range, risk or ident class");

  a_ident_needs_isn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && idc != ID_INSUFF |-> isn != ISN_INSUFF)
    else $error("ident class without sequence class");

  a_const_risk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && isn == ISN_CONST |-> risk >= RISK_ISN_CONST && risk <= 4'd9)
    else $error("constant increment without its risk weight");

endmodule

bind tcp_sample_set_fingerprinter_top tssf_checker u_tssf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the TCP sample set fingerprinter: random sets, idling, range limits.
module tb;
  import tssf_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;
  localparam int PHASE_BEATS = 425;
  localparam int SAMPLE_W    = $bits(sample_t);
  localparam int RESULT_W    = $bits(result_t);
  localparam int FLAG_POS [NUM_FLAGS] = '{SYN_BIT, ACK_BIT, PSH_BIT, RST_BIT, FIN_BIT};

  typedef struct {
    sample_t fields;
    logic    closes;
  } sample_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [31:0]           cfg_wr_data = '0;

  sample_beat_t sample_queue[$];
  sample_beat_t next_beat;
  result_t      expected_reports[$];
  int           beats_queued = 0;
  int           beats_accepted = 0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  // running set statistics
  logic [31:0] range_limit = LIMIT_RESET;
  int          held_count;
  logic [31:0] seq_prev, step_first, step_min, step_max;
  logic        steps_equal;
  logic [15:0] id_first, id_prev;
  logic [2:0]  id_pattern;
  logic [1:0]  id_risk;
  logic [31:0] stamp_first;
  logic        stamp2_zero;
  logic [15:0] win_prev;
  logic [5:0]  win_changes;
  logic [6:0]  flag_tally [NUM_FLAGS];

  tcp_sample_set_fingerprinter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic clear_set_stats();
    begin
      held_count  = 0;
      seq_prev    = '0;
      step_first  = '0;
      step_min    = '0;
      step_max    = '0;
      steps_equal = 1'b1;
      id_first    = '0;
      id_prev     = '0;
      id_pattern  = 3'b111;
      id_risk     = 2'b11;
      stamp_first = '0;
      stamp2_zero = 1'b0;
      win_prev    = '0;
      win_changes = '0;
      for (int k = 0; k < NUM_FLAGS; k++) flag_tally[k] = '0;
    end
  endtask

  task automatic fold_sample(input sample_t s, input logic closes);
    logic [31:0] step;
    logic        incr, same;
    result_t     r;
    begin
      if (held_count < MAX_SAMPLES_DEF) begin
        for (int k = 0; k < NUM_FLAGS; k++)
          if (s.tcp_flags[FLAG_POS[k]] && flag_tally[k] != FLAG_CNT_MAX)
            flag_tally[k] = flag_tally[k] + 7'd1;
        if (held_count == 0) begin
          id_first    = s.ident_value;
          stamp_first = s.stamp_value;
        end else begin
          step = s.sequence_number - seq_prev;
          incr = (id_prev != IDENT_MAX) && (s.ident_value == id_prev + 16'd1);
          same = (s.ident_value == id_prev);
          if (held_count == 1) begin
            step_first  = step;
            step_min    = step;
            step_max    = step;
            stamp2_zero = (s.stamp_value == '0);
          end else begin
            if (step != step_first) steps_equal = 1'b0;
            if (step < step_min) step_min = step;
            if (step > step_max) step_max = step;
            if (!incr) id_pattern[ID_INCR_BIT] = 1'b0;
            if (s.ident_value == id_first) id_pattern[ID_RANDOM_BIT] = 1'b0;
            if (!same) id_pattern[ID_CONST_BIT] = 1'b0;
          end
          if (!same) id_risk[RISK_CONST_BIT] = 1'b0;
          if (!incr) id_risk[RISK_INCR_BIT] = 1'b0;
          if (s.window_size != win_prev && win_changes != WIN_CNT_MAX)
            win_changes = win_changes + 6'd1;
        end
        seq_prev   = s.sequence_number;
        id_prev    = s.ident_value;
        win_prev   = s.window_size;
        held_count = held_count + 1;
      end
      if (closes) begin
        r = '0;
        r.isn_class   = ISN_INSUFF;
        r.ident_class = ID_INSUFF;
        if (held_count >= 2) begin
          r.delta_range = step_max - step_min;
          if (steps_equal) r.isn_class = ISN_CONST;
          else if (r.delta_range < range_limit) r.isn_class = ISN_PREDICT;
          else r.isn_class = ISN_RANDOM;
          r.stamps_present = (stamp_first != '0) || !stamp2_zero;
          if (steps_equal) r.risk_total = r.risk_total + RISK_ISN_CONST;
          if (held_count >= 3) begin
            if (id_risk[RISK_CONST_BIT]) r.risk_total = r.risk_total + RISK_ID_CONST;
            if (id_risk[RISK_INCR_BIT]) r.risk_total = r.risk_total + RISK_ID_INCR;
          end
          if (stamp_first != '0) r.risk_total = r.risk_total + RISK_STAMP;
        end
        if (held_count >= 3) begin
          if (id_pattern[ID_CONST_BIT]) r.ident_class = ID_CONST;
          else if (id_pattern[ID_INCR_BIT]) r.ident_class = ID_INCR;
          else if (id_pattern[ID_RANDOM_BIT]) r.ident_class = ID_RANDOM;
          else r.ident_class = ID_UNCLASS;
        end
        r.win_change_total = win_changes;
        r.syn_total        = flag_tally[CNT_SYN];
        r.ack_total        = flag_tally[CNT_ACK];
        r.psh_total        = flag_tally[CNT_PSH];
        r.rst_total        = flag_tally[CNT_RST];
        r.fin_total        = flag_tally[CNT_FIN];
        r.rst_warning      = flag_tally[CNT_RST] > (flag_tally[CNT_ACK] >> 1);
        expected_reports.push_back(r);
        clear_set_stats();
      end
    end
  endtask

  task automatic check_report(input result_t got);
    result_t want;
    string   bad;
    begin
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("report with nothing pending: got %h", got);
      end else begin
        want = expected_reports.pop_front();
        bad  = "";
        if (got.isn_class !== want.isn_class) bad = {bad, " isn_class"};
        if (got.delta_range !== want.delta_range) bad = {bad, " delta_range"};
        if (got.ident_class !== want.ident_class) bad = {bad, " ident_class"};
        if (got.stamps_present !== want.stamps_present) bad = {bad, " stamps_present"};
        if (got.win_change_total !== want.win_change_total) bad = {bad, " win_change_total"};
        if (got.syn_total !== want.syn_total) bad = {bad, " syn_total"};
        if (got.ack_total !== want.ack_total) bad = {bad, " ack_total"};
        if (got.psh_total !== want.psh_total) bad = {bad, " psh_total"};
        if (got.rst_total !== want.rst_total) bad = {bad, " rst_total"};
        if (got.fin_total !== want.fin_total) bad = {bad, " fin_total"};
        if (got.rst_warning !== want.rst_warning) bad = {bad, " rst_warning"};
        if (got.risk_total !== want.risk_total) bad = {bad, " risk_total"};
        if (bad != "") begin
          error_count++;
          if (error_count <= 10)
            $display("report mismatch:%s expected %h got %h", bad, want, got);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat = sample_queue.pop_front();
        in_tdata  <= IN_DATA_W'(next_beat.fields);
        in_tlast  <= next_beat.closes;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        fold_sample(in_tdata[SAMPLE_W-1:0], in_tlast);
        beats_accepted++;
      end
      if (out_tvalid && out_tready) check_report(out_tdata[RESULT_W-1:0]);
    end
  end

  task automatic push_beat(input logic [31:0] seq, input logic [15:0] id,
                           input logic [31:0] stamp, input logic [15:0] win,
                           input logic [8:0] flags, input logic closes);
    sample_beat_t b;
    begin
      b.fields.sequence_number = seq;
      b.fields.ident_value     = id;
      b.fields.stamp_value     = stamp;
      b.fields.window_size     = win;
      b.fields.tcp_flags       = flags;
      b.closes                 = closes;
      sample_queue.push_back(b);
      beats_queued++;
    end
  endtask

  task automatic queue_set(input int n);
    logic [31:0] seq, step, stamp;
    logic [15:0] id, win_a, win_b, win;
    logic [8:0]  flags;
    int          seq_mode, id_mode, stamp_mode, win_mode, flag_mode, jitter;
    bit          noisy;
    begin
      seq        = $urandom;
      step       = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5000);
      jitter     = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 2000) : $urandom;
      id         = ($urandom_range(0, 5) == 0) ? 16'hFFFD : 16'($urandom);
      win_a      = 16'($urandom);
      win_b      = 16'($urandom);
      seq_mode   = $urandom_range(0, 2);
      id_mode    = $urandom_range(0, 4);
      stamp_mode = $urandom_range(0, 3);
      win_mode   = $urandom_range(0, 2);
      flag_mode  = $urandom_range(0, 2);
      noisy      = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n; k++) begin
        case (id_mode)
          1: if (k != 0) id = id + 16'd1;
          2: id = 16'($urandom);
          3: id = '0;
          4: if (k != 0) id = id + (($urandom_range(0, 7) == 0) ? 16'd2 : 16'd1);
          default: ;
        endcase
        case (stamp_mode)
          0: stamp = '0;
          1: stamp = (k == 0) ? 32'd0 : $urandom;
          3: stamp = (k == 1) ? 32'd0 : $urandom;
          default: stamp = $urandom;
        endcase
        case (win_mode)
          0: win = win_a;
          1: win = ($urandom_range(0, 3) == 0) ? win_b : win_a;
          default: win = 16'($urandom);
        endcase
        case (flag_mode)
          0: flags = 9'($urandom_range(0, 511));
          1: flags = 9'(($urandom_range(0, 1) << RST_BIT) | ($urandom_range(0, 3) == 0) << ACK_BIT);
          default: flags = 9'($urandom_range(0, 31));
        endcase
        if (noisy)
          push_beat($urandom, 16'($urandom), $urandom, 16'($urandom),
                    9'($urandom_range(0, 511)), k == n - 1);
        else
          push_beat(seq, id, stamp, win, flags, k == n - 1);
        case (seq_mode)
          0: seq = seq + step;
          1: seq = seq + step + $urandom_range(0, jitter);
          default: seq = $urandom;
        endcase
      end
    end
  endtask

  task automatic queue_directed();
    begin
      push_beat('1, '1, '1, '1, '1, 1'b1);
      push_beat(32'hFFFF_FFF0, 16'h0001, 32'h0, 16'h1000, 9'(1 << ACK_BIT), 1'b0);
      push_beat(32'h0000_0010, 16'h0005, 32'h0, 16'h2000, 9'(1 << ACK_BIT), 1'b1);
      push_beat(32'd0, 16'hFFFE, 32'd0, 16'd5, 9'(1 << RST_BIT), 1'b0);
      push_beat(32'd100, 16'hFFFF, 32'd5, 16'd5, 9'(1 << RST_BIT), 1'b0);
      push_beat(32'd150, 16'h0000, 32'd7, 16'd6, 9'(1 << RST_BIT), 1'b1);
      for (int k = 0; k < 4; k++) push_beat('0, '0, (k == 0) ? 32'd1 : 32'd0, '0, '0, k == 3);
      for (int k = 0; k < 4; k++)
        push_beat(32'd1000 * (k + 1), 16'd10 + 16'(k), 32'h8000_0000, 16'(k),
                  9'((1 << FIN_BIT) | (1 << SYN_BIT) | (1 << PSH_BIT)), k == 3);
      push_beat(32'd0, 16'd7, 32'd3, 16'hFFFF, 9'h1E0, 1'b0);
      push_beat(32'hFFFF_FFFF, 16'd7, 32'd0, 16'h0000, 9'h1E0, 1'b0);
      push_beat(32'd0, 16'd7, 32'd9, 16'hFFFF, 9'h1E0, 1'b1);
    end
  endtask

  task automatic wait_drained();
    begin
      while (beats_accepted != beats_queued) @(posedge clk);
      while (expected_reports.size() != 0) @(posedge clk);
      repeat (DRAIN_WAIT) @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [31:0] value);
    begin
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= value;
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      range_limit = value;
    end
  endtask

  initial begin
    int phase_start;
    clear_set_stats();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_limit(32'd0);
          send_idle_pct  = 50;
          recv_stall_pct = 0;
        end
        2: begin
          write_limit(32'hFFFF_FFFF);
          send_idle_pct  = 0;
          recv_stall_pct = 50;
        end
        3: begin
          write_limit($urandom_range(1, 20000));
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
        default: queue_directed();
      endcase
      phase_start = beats_queued;
      queue_set(MAX_SAMPLES_DEF + $urandom_range(0, 6));
      while (beats_queued - phase_start < PHASE_BEATS) begin
        case ($urandom_range(0, 19))
          0: queue_set(MAX_SAMPLES_DEF + $urandom_range(0, 6));
          1, 2: queue_set($urandom_range(1, 2));
          default: queue_set($urandom_range(3, 12));
        endcase
      end
      wait_drained();
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
